/* hw/rtl/triangle_box_to_grid_cell_range_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the triangle box to grid cell range block
// Implication checks sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BOX_TO_GRID_CELL_RANGE_MACROS_SVH
`define TRIANGLE_BOX_TO_GRID_CELL_RANGE_MACROS_SVH

// same-cycle implication
`define TBGCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBGCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tbgcr_pkg.sv */
// ----------------------------------------------------------------------------
// tbgcr_pkg
// Shared codes and types for the triangle box to grid cell range block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbgcr_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BELOW = 2'd1,
    STATUS_ABOVE = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_SPACING_X = 3'd3,
    REG_SPACING_Y = 3'd4,
    REG_SPACING_Z = 3'd5,
    REG_PADDING   = 3'd6,
    REG_TOLERANCE = 3'd7
  } reg_index_t;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SPAC_W  = 31;
  localparam int unsigned CELL_W  = 6;
  localparam int unsigned TOTAL_W = 19;

  // side-band info that rides along with every item
  typedef struct packed {
    logic        valid;
    logic [15:0] tri_index;
    logic [31:0] tri_ident;
    status_t     status;
  } meta_t;

endpackage

`default_nettype wire

/* hw/rtl/triangle_box_to_grid_cell_range.sv */
// ----------------------------------------------------------------------------
// triangle_box_to_grid_cell_range
// Maps one triangle's padded bounding box onto a uniform grid cell range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one triangle per item (index, identifier, three
//   Q16.16 vertices). Output channel out_*: one result per item, same order.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low. cfg_* writes one register per valid&ready beat; cfg_ready
//   is always high. Write config only while no item is in flight.
//   Throughput: one item per cycle while no result is held by out_stall;
//   the divider is a restoring pipeline with one quotient bit per stage,
//   one per axis and range end. QW is the quotient width (7 at the
//   default 64 cells; 11 for grids of up to 1024 cells).
//   When out_stall is high while a result is held, the whole pipeline
//   freezes and in_stall follows; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits and loads origins
//   0, spacings 1.0, padding 0 and tolerance 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_box_to_grid_cell_range_macros.svh"

module triangle_box_to_grid_cell_range #(
  parameter int unsigned CELLS_X = 64,
  parameter int unsigned CELLS_Y = 64,
  parameter int unsigned CELLS_Z = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_tri_index,
  input  wire logic [31:0] in_tri_ident,
  input  wire logic signed [31:0] in_vertex_a_x,
  input  wire logic signed [31:0] in_vertex_a_y,
  input  wire logic signed [31:0] in_vertex_a_z,
  input  wire logic signed [31:0] in_vertex_b_x,
  input  wire logic signed [31:0] in_vertex_b_y,
  input  wire logic signed [31:0] in_vertex_b_z,
  input  wire logic signed [31:0] in_vertex_c_x,
  input  wire logic signed [31:0] in_vertex_c_y,
  input  wire logic signed [31:0] in_vertex_c_z,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_tri_index,
  output logic [31:0]      out_tri_ident,
  output logic [5:0]       out_first_cell_x,
  output logic [5:0]       out_first_cell_y,
  output logic [5:0]       out_first_cell_z,
  output logic [5:0]       out_last_cell_x,
  output logic [5:0]       out_last_cell_y,
  output logic [5:0]       out_last_cell_z,
  output logic [18:0]      out_cell_total,
  output logic [1:0]       out_status
);

  // --------------------------------------------------------------------------
  // Sizes. QW holds the largest quotient (= cell count), DW the offset from
  // origin (span = cells * spacing), CW a signed coordinate with margin for
  // origin +/- span +/- tolerance.
  // --------------------------------------------------------------------------
  localparam int unsigned CMAX_XY = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
  localparam int unsigned CMAX    = (CMAX_XY > CELLS_Z) ? CMAX_XY : CELLS_Z;
  localparam int unsigned QW      = $clog2(CMAX + 1);
  localparam int unsigned SW      = tbgcr_pkg::SPAC_W;
  localparam int unsigned DW      = SW + QW;
  localparam int unsigned CW      = DW + 3;
  localparam int unsigned XW      = QW + tbgcr_pkg::CELL_W;
  localparam int unsigned TW      = 3 * QW + tbgcr_pkg::TOTAL_W;
  localparam int unsigned NS      = 9 + QW;
  localparam int unsigned ST_DIV  = 6;
  localparam int unsigned ST_CNT  = ST_DIV + QW;
  localparam int unsigned CELLS_A [3] = '{CELLS_X, CELLS_Y, CELLS_Z};

  // --------------------------------------------------------------------------
  // Configuration registers and derived bounds
  // --------------------------------------------------------------------------
  logic signed [31:0] origin_r [3];
  logic [SW-1:0]      spacing_r [3];
  logic [SW-1:0]      pad_r;
  logic [SW-1:0]      tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        origin_r[a]  <= '0;
        spacing_r[a] <= SW'(65536);
      end
      pad_r <= '0;
      tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (tbgcr_pkg::reg_index_t'(cfg_index))
        tbgcr_pkg::REG_ORIGIN_X:  origin_r[0]  <= cfg_data;
        tbgcr_pkg::REG_ORIGIN_Y:  origin_r[1]  <= cfg_data;
        tbgcr_pkg::REG_ORIGIN_Z:  origin_r[2]  <= cfg_data;
        tbgcr_pkg::REG_SPACING_X: spacing_r[0] <= cfg_data[SW-1:0];
        tbgcr_pkg::REG_SPACING_Y: spacing_r[1] <= cfg_data[SW-1:0];
        tbgcr_pkg::REG_SPACING_Z: spacing_r[2] <= cfg_data[SW-1:0];
        tbgcr_pkg::REG_PADDING:   pad_r        <= cfg_data[SW-1:0];
        tbgcr_pkg::REG_TOLERANCE: tol_r        <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Bounds are registered from the configuration registers; the first item
  // stage that reads them follows input capture, so an item accepted after
  // a write sees the new bounds.
  logic [SW-1:0]        spe_r  [3];   // spacing, zero taken as one
  logic [DW-1:0]        span_r [3];
  logic signed [CW-1:0] lo_r   [3];
  logic signed [CW-1:0] hi_r   [3];
  logic signed [CW-1:0] lot_r  [3];   // lo - tolerance
  logic signed [CW-1:0] hit_r  [3];   // hi + tolerance

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic [SW-1:0] spe;
      logic [DW-1:0] span;
      spe       = (spacing_r[a] == '0) ? SW'(1) : spacing_r[a];
      span      = DW'(spe) * DW'(CELLS_A[a]);
      spe_r[a]  <= spe;
      span_r[a] <= span;
      lo_r[a]   <= CW'(origin_r[a]);
      hi_r[a]   <= CW'(origin_r[a]) + $signed(CW'(span));
      lot_r[a]  <= CW'(origin_r[a]) - $signed(CW'(tol_r));
      hit_r[a]  <= CW'(origin_r[a]) + $signed(CW'(span)) + $signed(CW'(tol_r));
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one global advance, frozen while out_stall holds a result.
  // --------------------------------------------------------------------------
  logic                en;
  tbgcr_pkg::meta_t    meta_r [NS];
  tbgcr_pkg::meta_t    meta_in;

  assign in_stall = meta_r[NS-1].valid & out_stall;
  assign en       = ~in_stall;

  always_comb begin
    meta_in           = '0;
    meta_in.valid     = in_valid;
    meta_in.tri_index = in_tri_index;
    meta_in.tri_ident = in_tri_ident;
    meta_in.status    = tbgcr_pkg::STATUS_OK;
  end

  // status is settled in the clamp stage; other stages copy meta as is
  tbgcr_pkg::status_t st_nxt;
  tbgcr_pkg::meta_t   meta_st;

  always_comb begin
    meta_st        = meta_r[0];
    meta_st.status = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) meta_r[s].valid <= 1'b0;
    end else if (en) begin
      meta_r[0] <= meta_in;
      meta_r[1] <= meta_st;
      for (int s = 2; s < NS; s++) meta_r[s] <= meta_r[s-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input capture
  // --------------------------------------------------------------------------
  logic signed [31:0] vtx_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      vtx_r[0] <= in_vertex_a_x; vtx_r[1] <= in_vertex_a_y; vtx_r[2] <= in_vertex_a_z;
      vtx_r[3] <= in_vertex_b_x; vtx_r[4] <= in_vertex_b_y; vtx_r[5] <= in_vertex_b_z;
      vtx_r[6] <= in_vertex_c_x; vtx_r[7] <= in_vertex_c_y; vtx_r[8] <= in_vertex_c_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: tolerance check and clamp of each coordinate
  // --------------------------------------------------------------------------
  logic                 below [9];
  logic                 above [9];
  logic signed [CW-1:0] cl_nxt [9];
  logic signed [CW-1:0] cl_r   [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      logic signed [CW-1:0] x;
      x        = CW'(vtx_r[i]);
      below[i] = x < lot_r[i % 3];
      above[i] = x > hit_r[i % 3];
      if (x < lo_r[i % 3])      cl_nxt[i] = lo_r[i % 3];
      else if (x > hi_r[i % 3]) cl_nxt[i] = hi_r[i % 3];
      else                      cl_nxt[i] = x;
    end
    // first failing coordinate in a.x .. c.z order wins
    st_nxt = tbgcr_pkg::STATUS_OK;
    for (int i = 8; i >= 0; i--) begin
      if (below[i])      st_nxt = tbgcr_pkg::STATUS_BELOW;
      else if (above[i]) st_nxt = tbgcr_pkg::STATUS_ABOVE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) cl_r <= cl_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 2: box min/max per axis
  // Stage 3: offsets from origin
  // Stage 4: padding, clamped to the domain
  // Stage 5: numerators (first cell uses d-1 so floor gives ceil-1)
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] mn_r [3], mx_r [3];
  logic signed [CW-1:0] ra_r [3], rb_r [3];
  logic [DW-1:0]        dmin_r [3], dmax_r [3];
  logic [DW-1:0]        numf_r [3], numl_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [CW-1:0] m0, m1, p0, p1, dn, dx;
        m0 = (cl_r[a] < cl_r[3+a]) ? cl_r[a] : cl_r[3+a];
        p0 = (cl_r[a] > cl_r[3+a]) ? cl_r[a] : cl_r[3+a];
        m1 = (m0 < cl_r[6+a]) ? m0 : cl_r[6+a];
        p1 = (p0 > cl_r[6+a]) ? p0 : cl_r[6+a];
        mn_r[a] <= m1;
        mx_r[a] <= p1;

        ra_r[a] <= mn_r[a] - lo_r[a];
        rb_r[a] <= mx_r[a] - lo_r[a];

        dn = ra_r[a] - $signed(CW'(pad_r));
        dx = rb_r[a] + $signed(CW'(pad_r));
        dmin_r[a] <= dn[CW-1] ? '0 : dn[DW-1:0];
        dmax_r[a] <= (dx > $signed(CW'(span_r[a]))) ? span_r[a] : dx[DW-1:0];

        numf_r[a] <= (dmin_r[a] == '0) ? '0 : dmin_r[a] - DW'(1);
        numl_r[a] <= dmax_r[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, MSB first.
  // Lane 2a is the first-cell numerator, lane 2a+1 the last-cell numerator.
  // The quotient never exceeds the cell count, so QW bits suffice.
  // --------------------------------------------------------------------------
  logic [DW-1:0] rem_r [QW][6];
  logic [QW-1:0] quo_r [QW][6];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned K = QW - 1 - j;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 6; l++) begin
          logic [DW-1:0] rin, dv;
          logic [QW-1:0] qin;
          if (j == 0) begin
            rin = (l % 2 == 0) ? numf_r[l / 2] : numl_r[l / 2];
            qin = '0;
          end else begin
            rin = rem_r[(j == 0) ? 0 : j - 1][l];
            qin = quo_r[(j == 0) ? 0 : j - 1][l];
          end
          dv = DW'(spe_r[l / 2]) << K;
          if (rin >= dv) begin
            rem_r[j][l] <= rin - dv;
            quo_r[j][l] <= qin | (QW'(1) << K);
          end else begin
            rem_r[j][l] <= rin;
            quo_r[j][l] <= qin;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Limit to the grid, per-axis counts, then the product over two stages.
  // --------------------------------------------------------------------------
  logic [QW-1:0]   fc_r [3], lc_r [3], cnt_r [3];
  logic [2*QW-1:0] pxy_r;
  logic [QW-1:0]   fc2_r [3], lc2_r [3], cz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic [QW-1:0] top, f, l;
        top = QW'(CELLS_A[a] - 1);
        f   = (quo_r[QW-1][2*a]   > top) ? top : quo_r[QW-1][2*a];
        l   = (quo_r[QW-1][2*a+1] > top) ? top : quo_r[QW-1][2*a+1];
        fc_r[a]  <= f;
        lc_r[a]  <= l;
        cnt_r[a] <= l - f + QW'(1);
      end
      pxy_r <= (2*QW)'(cnt_r[0]) * (2*QW)'(cnt_r[1]);
      cz_r  <= cnt_r[2];
      fc2_r <= fc_r;
      lc2_r <= lc_r;
    end
  end

  // output register
  logic [tbgcr_pkg::CELL_W-1:0]  first_r [3], last_r [3];
  logic [tbgcr_pkg::TOTAL_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic          ok;
      logic [TW-1:0] tot;
      ok  = (meta_r[ST_CNT+1].status == tbgcr_pkg::STATUS_OK);
      tot = TW'(pxy_r) * TW'(cz_r);
      for (int a = 0; a < 3; a++) begin
        logic [XW-1:0] fx, lx;
        fx = XW'(fc2_r[a]);
        lx = XW'(lc2_r[a]);
        first_r[a] <= ok ? fx[tbgcr_pkg::CELL_W-1:0] : '0;
        last_r[a]  <= ok ? lx[tbgcr_pkg::CELL_W-1:0] : '0;
      end
      total_r <= ok ? tot[tbgcr_pkg::TOTAL_W-1:0] : '0;
    end
  end

  assign out_valid        = meta_r[NS-1].valid;
  assign out_tri_index    = meta_r[NS-1].tri_index;
  assign out_tri_ident    = meta_r[NS-1].tri_ident;
  assign out_status       = meta_r[NS-1].status;
  assign out_first_cell_x = first_r[0];
  assign out_first_cell_y = first_r[1];
  assign out_first_cell_z = first_r[2];
  assign out_last_cell_x  = last_r[0];
  assign out_last_cell_y  = last_r[1];
  assign out_last_cell_z  = last_r[2];
  assign out_cell_total   = total_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TBGCR_ASSERT_IMP(a_err_zero, out_valid && out_status != tbgcr_pkg::STATUS_OK,
                    out_cell_total == '0 && out_last_cell_x == '0, "error result not cleared")
  `TBGCR_ASSERT_IMP(a_status_code, out_valid,
                    out_status == tbgcr_pkg::STATUS_OK || out_status == tbgcr_pkg::STATUS_BELOW
                    || out_status == tbgcr_pkg::STATUS_ABOVE, "undefined status code")
  `TBGCR_ASSERT_NXT(a_freeze, in_stall,
                    $stable(meta_r[ST_DIV].valid) && $stable(quo_r[QW-1][1]),
                    "pipeline moved while frozen")

endmodule

`default_nettype wire

/* tb/triangle_box_to_grid_cell_range_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for triangle_box_to_grid_cell_range
// Streams triangles through the block under several grid settings. Every
// result is compared field by field with an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_box_to_grid_cell_range_tb;

  localparam int unsigned CELLS   = 64;
  localparam int          WDOG    = 20000;
  localparam int          DRAIN   = 40;
  localparam int          N_RAND  = 950;

  // one triangle as driven on the input port
  typedef struct {
    logic [15:0]        idx;
    logic [31:0]        ident;
    logic signed [31:0] v [9];
  } tri_t;

  // one cell range result
  typedef struct {
    logic [15:0] idx;
    logic [31:0] ident;
    logic [5:0]  first [3];
    logic [5:0]  last [3];
    logic [18:0] total;
    tbgcr_pkg::status_t status;
  } range_t;

  // directed rows; chk_* typed-in values are used when has_chk is set
  typedef struct {
    tri_t    t;
    bit      has_chk;
    tbgcr_pkg::status_t chk_status;
    int      chk_total;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_tri_index = '0;
  logic [31:0] in_tri_ident = '0;
  logic signed [31:0] in_v [9];
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_tri_index;
  logic [31:0] out_tri_ident;
  logic [5:0]  out_fx, out_fy, out_fz, out_lx, out_ly, out_lz;
  logic [18:0] out_cell_total;
  logic [1:0]  out_status;

  initial for (int i = 0; i < 9; i++) in_v[i] = '0;

  triangle_box_to_grid_cell_range u_dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_tri_index, .in_tri_ident,
    .in_vertex_a_x(in_v[0]), .in_vertex_a_y(in_v[1]), .in_vertex_a_z(in_v[2]),
    .in_vertex_b_x(in_v[3]), .in_vertex_b_y(in_v[4]), .in_vertex_b_z(in_v[5]),
    .in_vertex_c_x(in_v[6]), .in_vertex_c_y(in_v[7]), .in_vertex_c_z(in_v[8]),
    .out_valid, .out_stall, .out_tri_index, .out_tri_ident,
    .out_first_cell_x(out_fx), .out_first_cell_y(out_fy), .out_first_cell_z(out_fz),
    .out_last_cell_x(out_lx), .out_last_cell_y(out_ly), .out_last_cell_z(out_lz),
    .out_cell_total, .out_status
  );

  // grid settings held by the predictor
  logic signed [63:0] grid_origin [3];
  logic [63:0]        grid_spacing [3];
  logic [63:0]        box_pad, edge_tol;

  range_t expected_ranges [$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     no_idling = 1'b0;
  bit     hold_out = 1'b0;

  function automatic range_t predict_range(tri_t t);
    range_t r;
    logic signed [63:0] lo [3], hi [3], mn [3], mx [3];
    logic signed [63:0] c, pmin, pmax;
    logic [63:0] sp, dmin, dmax, q, f, l, total;
    tbgcr_pkg::status_t st;
    st = tbgcr_pkg::STATUS_OK;
    total = 1;
    for (int a = 0; a < 3; a++) begin
      sp = (grid_spacing[a] == 0) ? 64'd1 : grid_spacing[a];
      lo[a] = grid_origin[a];
      hi[a] = grid_origin[a] + $signed(CELLS * sp);
      mn[a] = hi[a];
      mx[a] = lo[a];
    end
    // coordinates checked in a.x, a.y, ... c.z order; first failure wins
    for (int i = 0; i < 9 && st == tbgcr_pkg::STATUS_OK; i++) begin
      c = t.v[i];
      if (c < lo[i % 3]) begin
        if (lo[i % 3] - c > $signed(edge_tol)) st = tbgcr_pkg::STATUS_BELOW;
        else c = lo[i % 3];
      end else if (c > hi[i % 3]) begin
        if (c - hi[i % 3] > $signed(edge_tol)) st = tbgcr_pkg::STATUS_ABOVE;
        else c = hi[i % 3];
      end
      if (st == tbgcr_pkg::STATUS_OK) begin
        if (c < mn[i % 3]) mn[i % 3] = c;
        if (c > mx[i % 3]) mx[i % 3] = c;
      end
    end
    r.idx = t.idx;
    r.ident = t.ident;
    r.status = st;
    r.total = '0;
    for (int a = 0; a < 3; a++) begin
      r.first[a] = '0;
      r.last[a] = '0;
    end
    if (st != tbgcr_pkg::STATUS_OK) return r;
    for (int a = 0; a < 3; a++) begin
      sp = (grid_spacing[a] == 0) ? 64'd1 : grid_spacing[a];
      pmin = mn[a] - $signed(box_pad);
      pmax = mx[a] + $signed(box_pad);
      if (pmin < lo[a]) pmin = lo[a];
      if (pmax > hi[a]) pmax = hi[a];
      dmin = pmin - lo[a];
      dmax = pmax - lo[a];
      q = (dmin + sp - 1) / sp;
      f = (q == 0) ? 64'd0 : q - 1;
      l = dmax / sp;
      if (f > CELLS - 1) f = CELLS - 1;
      if (l > CELLS - 1) l = CELLS - 1;
      r.first[a] = f[5:0];
      r.last[a] = l[5:0];
      total = total * (l - f + 1);
    end
    r.total = total[18:0];
    return r;
  endfunction

  task automatic write_reg(tbgcr_pkg::reg_index_t ri, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (ri)
      tbgcr_pkg::REG_ORIGIN_X, tbgcr_pkg::REG_ORIGIN_Y, tbgcr_pkg::REG_ORIGIN_Z:
        grid_origin[ri] = $signed(val);
      tbgcr_pkg::REG_SPACING_X, tbgcr_pkg::REG_SPACING_Y, tbgcr_pkg::REG_SPACING_Z:
        grid_spacing[ri - tbgcr_pkg::REG_SPACING_X] = {33'd0, val[30:0]};
      tbgcr_pkg::REG_PADDING:   box_pad = {33'd0, val[30:0]};
      tbgcr_pkg::REG_TOLERANCE: edge_tol = {33'd0, val[30:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for all results, then let the pipeline settle before a register write
  task automatic drain_pipe();
    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // offer one triangle, with an optional idle burst ahead of it
  task automatic send_tri(tri_t t);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tri_index <= t.idx;
    in_tri_ident <= t.ident;
    for (int i = 0; i < 9; i++) in_v[i] <= t.v[i];
    do @(posedge clk); while (in_stall);
    expected_ranges.insert(expected_ranges.size(), predict_range(t));
  endtask

  function automatic logic signed [31:0] rand_coord(int a, int mode);
    logic signed [63:0] lo, hi, c;
    lo = grid_origin[a];
    hi = grid_origin[a] + $signed(CELLS * ((grid_spacing[a] == 0) ? 64'd1 : grid_spacing[a]));
    case (mode)
      0: c = lo + $signed({32'd0, $urandom()} % (hi - lo + 1));
      1: c = lo - $signed({32'd0, $urandom_range(0, 3)}) * $signed(edge_tol + 1) / 2;
      2: c = hi + $signed({32'd0, $urandom_range(0, 3)}) * $signed(edge_tol + 1) / 2;
      default: return $signed($urandom());
    endcase
    if (c > 64'sh7FFFFFFF) c = 64'sh7FFFFFFF;
    if (c < -64'sh80000000) c = -64'sh80000000;
    return c[31:0];
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int sel;
    t.idx = 16'($urandom());
    t.ident = $urandom();
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      // mostly in-domain triangles, some near the edges, a few raw values
      if (sel < 7) t.v[i] = rand_coord(i % 3, ($urandom_range(0, 11) == 0) ? 1 : 0);
      else if (sel < 9) t.v[i] = rand_coord(i % 3, $urandom_range(0, 2));
      else t.v[i] = rand_coord(i % 3, 3);
    end
    return t;
  endfunction

  function automatic tri_t make_tri(int id, logic signed [31:0] p, logic signed [31:0] q);
    tri_t t;
    t.idx = id[15:0];
    t.ident = 32'hA500_0000 + id;
    for (int i = 0; i < 9; i++) t.v[i] = (i < 3) ? p : q;
    return t;
  endfunction

  // receiver: checks every result; stall bursts come from the stall driver
  always @(posedge clk) begin
    range_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ranges.size() == 0) begin
        $error("result with no triangle pending, index %0d", out_tri_index);
        fail_count++;
      end else begin
        exp_r = expected_ranges.pop_front();
        if (out_tri_index !== exp_r.idx) begin
          $error("tri_index exp %0d got %0d", exp_r.idx, out_tri_index); fail_count++;
        end
        if (out_tri_ident !== exp_r.ident) begin
          $error("tri_ident exp %h got %h", exp_r.ident, out_tri_ident); fail_count++;
        end
        if (out_fx !== exp_r.first[0]) begin
          $error("first_cell_x exp %0d got %0d", exp_r.first[0], out_fx); fail_count++;
        end
        if (out_fy !== exp_r.first[1]) begin
          $error("first_cell_y exp %0d got %0d", exp_r.first[1], out_fy); fail_count++;
        end
        if (out_fz !== exp_r.first[2]) begin
          $error("first_cell_z exp %0d got %0d", exp_r.first[2], out_fz); fail_count++;
        end
        if (out_lx !== exp_r.last[0]) begin
          $error("last_cell_x exp %0d got %0d", exp_r.last[0], out_lx); fail_count++;
        end
        if (out_ly !== exp_r.last[1]) begin
          $error("last_cell_y exp %0d got %0d", exp_r.last[1], out_ly); fail_count++;
        end
        if (out_lz !== exp_r.last[2]) begin
          $error("last_cell_z exp %0d got %0d", exp_r.last[2], out_lz); fail_count++;
        end
        if (out_cell_total !== exp_r.total) begin
          $error("cell_total exp %0d got %0d", exp_r.total, out_cell_total); fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_status); fail_count++;
        end
      end
    end
  end

  // stall driver: long hold on request, else random bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no handshake on the input, output or config channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t  rows [$];
    row_t  rw;
    range_t got_r;
    grid_origin = '{0, 0, 0};
    grid_spacing = '{65536, 65536, 65536};
    box_pad = 0;
    edge_tol = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset settings: domain 0 .. 64.0 on each axis
    rw.has_chk = 1'b1;
    rw.t = make_tri(0, 0, 0);
    rw.chk_status = tbgcr_pkg::STATUS_OK; rw.chk_total = 1;
    rows.insert(rows.size(), rw);
    rw.t = make_tri(1, 32'sd4194304, 32'sd4194304);
    rw.chk_status = tbgcr_pkg::STATUS_OK; rw.chk_total = 1;
    rows.insert(rows.size(), rw);
    rw.t = make_tri(2, 0, 32'sd4194304);
    rw.chk_status = tbgcr_pkg::STATUS_OK; rw.chk_total = 262144;
    rows.insert(rows.size(), rw);
    rw.t = make_tri(3, -32'sd1, 0);
    rw.chk_status = tbgcr_pkg::STATUS_BELOW; rw.chk_total = 0;
    rows.insert(rows.size(), rw);
    rw.t = make_tri(4, 0, 32'sd4194305);
    rw.chk_status = tbgcr_pkg::STATUS_ABOVE; rw.chk_total = 0;
    rows.insert(rows.size(), rw);
    rw.t = make_tri(5, 32'sh80000000, 32'sh7FFFFFFF);
    rw.chk_status = tbgcr_pkg::STATUS_BELOW; rw.chk_total = 0;
    rows.insert(rows.size(), rw);
    rw.t = make_tri(6, 32'sh7FFFFFFF, 32'sh80000000);
    rw.chk_status = tbgcr_pkg::STATUS_ABOVE; rw.chk_total = 0;
    rows.insert(rows.size(), rw);
    rw.has_chk = 1'b0;
    // error order: a later below beats nothing, earlier above wins
    rw.t = make_tri(7, 65536, 65536);
    rw.t.v[1] = 32'sh7FFFFFFF; rw.t.v[5] = -32'sd5; rows.insert(rows.size(), rw);
    // cell boundaries on and just off a grid line
    rw.t = make_tri(8, 32'sd131072, 32'sd131073); rows.insert(rows.size(), rw);
    rw.t = make_tri(9, 32'sd131071, 32'sd196608); rows.insert(rows.size(), rw);
    rw.t.idx = 16'hFFFF; rw.t.ident = 32'hFFFF_FFFF; rows.insert(rows.size(), rw);

    foreach (rows[i]) begin
      send_tri(rows[i].t);
      if (rows[i].has_chk) begin
        got_r = expected_ranges[expected_ranges.size() - 1];
        if (got_r.status != rows[i].chk_status || got_r.total != rows[i].chk_total) begin
          $error("directed row %0d: status exp %0d got %0d, total exp %0d got %0d",
                 i, rows[i].chk_status, got_r.status, rows[i].chk_total, got_r.total);
          fail_count++;
        end
      end
    end
    in_valid <= 1'b0;
    drain_pipe();

    // settings sweep: extremes, tolerance, padding, zero spacing, odd origins
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tbgcr_pkg::REG_TOLERANCE, 32'd65536);
          write_reg(tbgcr_pkg::REG_PADDING, 32'd32768);
        end
        1: begin
          write_reg(tbgcr_pkg::REG_ORIGIN_X, 32'h8000_0000);
          write_reg(tbgcr_pkg::REG_ORIGIN_Y, 32'hFFFF_0000);
          write_reg(tbgcr_pkg::REG_ORIGIN_Z, 32'h0012_3456);
          write_reg(tbgcr_pkg::REG_SPACING_X, 32'd1);
          write_reg(tbgcr_pkg::REG_SPACING_Y, 32'd12345);
          write_reg(tbgcr_pkg::REG_SPACING_Z, 32'd0);
        end
        2: begin
          write_reg(tbgcr_pkg::REG_ORIGIN_X, 32'hC000_0000);
          write_reg(tbgcr_pkg::REG_SPACING_X, 32'd16777216);
          write_reg(tbgcr_pkg::REG_PADDING, 32'h7FFF_FFFF);
          write_reg(tbgcr_pkg::REG_TOLERANCE, 32'd0);
        end
        3: begin
          write_reg(tbgcr_pkg::REG_ORIGIN_Y, 32'h7FFF_0000);
          write_reg(tbgcr_pkg::REG_SPACING_Y, 32'h7FFF_FFFF);
          write_reg(tbgcr_pkg::REG_PADDING, 32'd0);
          write_reg(tbgcr_pkg::REG_TOLERANCE, 32'h7FFF_FFFF);
        end
        4: begin
          write_reg(tbgcr_pkg::REG_ORIGIN_X, $urandom());
          write_reg(tbgcr_pkg::REG_ORIGIN_Y, $urandom());
          write_reg(tbgcr_pkg::REG_ORIGIN_Z, $urandom());
          write_reg(tbgcr_pkg::REG_SPACING_X, $urandom_range(1, 300000));
          write_reg(tbgcr_pkg::REG_SPACING_Y, $urandom_range(1, 300000));
          write_reg(tbgcr_pkg::REG_SPACING_Z, $urandom_range(1, 300000));
          write_reg(tbgcr_pkg::REG_PADDING, $urandom_range(0, 400000));
          write_reg(tbgcr_pkg::REG_TOLERANCE, $urandom_range(0, 100000));
        end
        default: begin
          // back to unit grid, random padding and tolerance; last phase runs flat out
          write_reg(tbgcr_pkg::REG_ORIGIN_X, 32'd0);
          write_reg(tbgcr_pkg::REG_ORIGIN_Y, 32'd0);
          write_reg(tbgcr_pkg::REG_ORIGIN_Z, 32'd0);
          write_reg(tbgcr_pkg::REG_SPACING_X, 32'd65536);
          write_reg(tbgcr_pkg::REG_SPACING_Y, 32'd65536);
          write_reg(tbgcr_pkg::REG_SPACING_Z, 32'd65536);
          write_reg(tbgcr_pkg::REG_PADDING, $urandom_range(0, 200000));
          write_reg(tbgcr_pkg::REG_TOLERANCE, $urandom_range(0, 70000));
        end
      endcase
      if (ph == 5) no_idling = 1'b1;
      if (ph == 2) hold_out = 1'b1;   // back-pressure fills the pipe
      for (int k = 0; k < N_RAND / 6; k++) send_tri(rand_tri());
      in_valid <= 1'b0;
      drain_pipe();
    end

    if (fail_count == 0 && expected_ranges.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
